@@ rtl/eth_ipv4_l4_header_parser_top_assert.svh @@
// assertion macros for the header parser top level
`ifndef ETH_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH
`define ETH_IPV4_L4_HEADER_PARSER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define EIPL4_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EIPL4_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/eipl4_pkg.sv @@
package eipl4_pkg;

  localparam int unsigned MAX_FRAME_BYTES = 65535;
  localparam int unsigned POS_W           = 16;

  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;
  localparam logic [7:0]  ETH_HDR_BYTES    = 8'd14;
  localparam logic [7:0]  UDP_HDR_BYTES    = 8'd8;
  localparam logic [12:0] FRAG_OFFSET_MASK = 13'h1fff;

  typedef enum logic [2:0] {
    LAYER_NONE = 3'd0,
    LAYER_ETH  = 3'd1,
    LAYER_IPV4 = 3'd2,
    LAYER_TCP  = 3'd3,
    LAYER_UDP  = 3'd4
  } layer_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_end;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  layer_class;
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  tcp_flag_bits;
    logic [1:0]  frag_flag_bits;
    logic [15:0] frag_offset_bytes;
    logic [7:0]  payload_start;
    logic [15:0] payload_bytes;
  } out_beat_t;

  // header fields latched over one frame
  typedef struct packed {
    logic [POS_W-1:0] len;
    logic [47:0]      dmac;
    logic [47:0]      smac;
    logic [15:0]      etype;
    logic [3:0]       ihl;
    logic [7:0]       proto;
    logic [31:0]      sip;
    logic [31:0]      dip;
    logic [15:0]      frag;
    logic [3:0]       doff;
    logic [15:0]      sport;
    logic [15:0]      dport;
    logic [7:0]       flags;
  } frame_hdr_t;

endpackage

@@ rtl/eipl4_field_latch.sv @@
module eipl4_field_latch
  import eipl4_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  in_beat_t   beat_i,
  output frame_hdr_t hdr_o
);

  frame_hdr_t       frame_q, frame_d, nxt;
  logic [POS_W-1:0] pos;
  logic [7:0]       b;
  logic [3:0]       ihl_eff;
  logic [POS_W-1:0] l4;
  logic [POS_W-1:0] r;

  assign pos = frame_q.len;
  assign b   = beat_i.frame_byte;

  always_comb begin
    nxt     = frame_q;
    ihl_eff = (pos == POS_W'(14)) ? b[3:0] : frame_q.ihl;
    l4      = POS_W'(ETH_HDR_BYTES) + {{(POS_W-6){1'b0}}, ihl_eff, 2'b00};
    r       = pos - l4;
    if (pos != POS_W'(MAX_FRAME_BYTES)) begin
      for (int k = 0; k < 6; k++) begin
        if (pos == POS_W'(k))      nxt.dmac[8*(5-k) +: 8] = b;
        if (pos == POS_W'(k + 6))  nxt.smac[8*(5-k) +: 8] = b;
      end
      for (int k = 0; k < 4; k++) begin
        if (pos == POS_W'(k + 26)) nxt.sip[8*(3-k) +: 8] = b;
        if (pos == POS_W'(k + 30)) nxt.dip[8*(3-k) +: 8] = b;
      end
      if (pos == POS_W'(12)) nxt.etype[15:8] = b;
      if (pos == POS_W'(13)) nxt.etype[7:0]  = b;
      if (pos == POS_W'(14)) nxt.ihl         = b[3:0];
      if (pos == POS_W'(20)) nxt.frag[15:8]  = b;
      if (pos == POS_W'(21)) nxt.frag[7:0]   = b;
      if (pos == POS_W'(23)) nxt.proto       = b;
      // layer-4 fields, placed by the header length just seen
      if (pos >= l4) begin
        case (r)
          POS_W'(0):  nxt.sport[15:8] = b;
          POS_W'(1):  nxt.sport[7:0]  = b;
          POS_W'(2):  nxt.dport[15:8] = b;
          POS_W'(3):  nxt.dport[7:0]  = b;
          POS_W'(12): nxt.doff        = b[7:4];
          POS_W'(13): nxt.flags       = b;
          default: ;
        endcase
      end
      nxt.len = pos + POS_W'(1);
    end
  end

  always_comb begin
    frame_d = frame_q;
    if (accept_i) begin
      frame_d = beat_i.frame_end ? '0 : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else begin
      frame_q <= frame_d;
    end
  end

  assign hdr_o = nxt;

endmodule

@@ rtl/eth_ipv4_l4_header_parser_top.sv @@
// the accepted last byte of a frame goes through the snapshot register, then the result register, to its result beat
// throughput: one frame byte per cycle while in_stall_o is low, set by the field latch stage
// a frame of n bytes yields one result beat, at its last byte only
// reset: the field latch's fields and byte count and the valid flags clear at once;
// snapshot and result payloads are not reset; link_q comes up as 1
module eth_ipv4_l4_header_parser_top
  import eipl4_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  `include "eth_ipv4_l4_header_parser_top_assert.svh"

  // config register
  logic link_q, link_d;

  // handshake
  logic in_accept;
  logic snap_adv;
  logic out_load;

  // frame snapshot, taken at the last byte
  frame_hdr_t hdr_next;
  frame_hdr_t snap_q, snap_d;
  logic       snap_valid_q, snap_valid_d;

  // result register
  out_beat_t res;
  out_beat_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  // classify terms
  logic [7:0]  l4_start;
  logic [7:0]  start;
  logic        is_ipv4;

  assign link_d = cfg_we_i ? cfg_wdata_i : link_q;

  // output side frees a slot when empty or when its beat is taken
  assign out_load   = !out_valid_q || !out_stall_i;
  assign snap_adv   = snap_valid_q && out_load;
  // hold the byte stream only while a finished frame is stuck in the snapshot
  assign in_stall_o = snap_valid_q && !snap_adv;
  assign in_accept  = in_valid_i && !in_stall_o;

  eipl4_field_latch u_latch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .beat_i   (in_data_i),
    .hdr_o    (hdr_next)
  );

  always_comb begin
    snap_d       = snap_q;
    snap_valid_d = snap_valid_q && !snap_adv;
    if (in_accept && in_data_i.frame_end) begin
      snap_d       = hdr_next;
      snap_valid_d = 1'b1;
    end
  end

  // result from the snapshot: class, offsets and gated fields
  always_comb begin
    is_ipv4  = (snap_q.etype == ETHERTYPE_IPV4);
    l4_start = ETH_HDR_BYTES + {2'b00, snap_q.ihl, 2'b00};
    res      = '0;
    start    = ETH_HDR_BYTES;
    if (link_q) begin
      res.dest_mac    = snap_q.dmac;
      res.source_mac  = snap_q.smac;
      res.layer_class = LAYER_ETH;
      if (is_ipv4) begin
        res.source_ip         = snap_q.sip;
        res.dest_ip           = snap_q.dip;
        res.frag_flag_bits    = snap_q.frag[14:13];
        res.frag_offset_bytes = {snap_q.frag[12:0] & FRAG_OFFSET_MASK, 3'b000};
        if (snap_q.proto == PROTO_TCP) begin
          res.layer_class   = LAYER_TCP;
          res.source_port   = snap_q.sport;
          res.dest_port     = snap_q.dport;
          res.tcp_flag_bits = snap_q.flags;
          start             = l4_start + {2'b00, snap_q.doff, 2'b00};
        end else if (snap_q.proto == PROTO_UDP) begin
          res.layer_class = LAYER_UDP;
          res.source_port = snap_q.sport;
          res.dest_port   = snap_q.dport;
          start           = l4_start + UDP_HDR_BYTES;
        end else begin
          res.layer_class = LAYER_IPV4;
          start           = l4_start;
        end
      end
      res.payload_start = start;
      // payload length floors at zero on short frames
      res.payload_bytes = (snap_q.len > {8'b0, start}) ? (snap_q.len - {8'b0, start})
                                                        : 16'd0;
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = snap_valid_q;
      if (snap_valid_q) begin
        out_d = res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_q       <= 1'b1;
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      link_q       <= link_d;
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    snap_q <= snap_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a last byte always lands in the snapshot
  `EIPL4_ASSERT_NEXT(a_last_to_snap, in_accept && in_data_i.frame_end, snap_valid_q, "last beat lost")
  // an unparsed result carries no offsets
  `EIPL4_ASSERT_NOW(a_none_zero, out_valid_o && out_data_o.layer_class == LAYER_NONE, out_data_o.payload_start == 8'd0 && out_data_o.payload_bytes == 16'd0 && out_data_o.dest_mac == 48'd0, "unparsed beat not zero")
  // plain ethernet payload starts right after the mac header
  `EIPL4_ASSERT_NOW(a_eth_start, out_valid_o && out_data_o.layer_class == LAYER_ETH, out_data_o.payload_start == ETH_HDR_BYTES && out_data_o.source_ip == 32'd0, "bad ethernet payload start")

endmodule

@@ tb/eth_ipv4_l4_header_parser_top_tb.sv @@
module eth_ipv4_l4_header_parser_top_tb;
  import eipl4_pkg::*;

  // timing of the run
  localparam int unsigned SETTLE_CYCLES  = 8;     // extra wait once every owed summary is out
  localparam int unsigned HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with no beat moving on either side

  // receiver stall patterns
  typedef enum int unsigned {
    STALL_NONE,
    STALL_RAND,
    STALL_TOGGLE
  } stall_mode_e;

  // one directed beat, with the summary typed in where it is obvious
  typedef struct packed {
    logic      link;
    in_beat_t  beat;
    logic      typed;
    out_beat_t want;
  } dir_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_data_o;
  logic      cfg_we_i;
  logic      cfg_wdata_i;

  eth_ipv4_l4_header_parser_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // mirror of the parser: link setting and the fields latched so far
  logic        link_on = 1'b1;
  int unsigned pos_cnt = 0;
  logic [47:0] mac_dst = '0;
  logic [47:0] mac_src = '0;
  logic [15:0] eth_type = '0;
  logic [3:0]  ip_ihl = '0;
  logic [7:0]  ip_proto = '0;
  logic [31:0] ip_src = '0;
  logic [31:0] ip_dst = '0;
  logic [15:0] ip_frag = '0;
  logic [3:0]  tcp_doff = '0;
  logic [15:0] l4_sport = '0;
  logic [15:0] l4_dport = '0;
  logic [7:0]  tcp_flags = '0;

  // frame summaries still owed by the parser, oldest first
  out_beat_t   pending_summaries[$];
  dir_row_t    dir_tab[$];
  logic [7:0]  frame_buf[$];

  int unsigned mismatches   = 0;
  int unsigned rand_bytes   = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_max      = 0;
  int unsigned idle_cycles  = 0;
  logic        hold_req     = 1'b0;

  // latch one byte by its position; on the last byte work out the frame summary
  task automatic predict_summary(input in_beat_t b, output bit done, output out_beat_t s);
    int unsigned p, l4, r, start;
    done = 1'b0;
    s    = '0;
    p    = pos_cnt;
    if (p < MAX_FRAME_BYTES) begin
      if (p < 6) mac_dst[8*(5-p) +: 8] = b.frame_byte;
      else if (p < 12) mac_src[8*(11-p) +: 8] = b.frame_byte;
      else if (p == 12) eth_type[15:8] = b.frame_byte;
      else if (p == 13) eth_type[7:0] = b.frame_byte;
      else if (p == 14) ip_ihl = b.frame_byte[3:0];
      else if (p == 20) ip_frag[15:8] = b.frame_byte;
      else if (p == 21) ip_frag[7:0] = b.frame_byte;
      else if (p == 23) ip_proto = b.frame_byte;
      else if (p >= 26 && p <= 29) ip_src[8*(29-p) +: 8] = b.frame_byte;
      else if (p >= 30 && p <= 33) ip_dst[8*(33-p) +: 8] = b.frame_byte;
      // layer 4 bytes may overlap a short ip header, the same byte feeds both
      l4 = ETH_HDR_BYTES + 4 * ip_ihl;
      if (p >= l4) begin
        r = p - l4;
        if (r < 2) l4_sport[8*(1-r) +: 8] = b.frame_byte;
        else if (r < 4) l4_dport[8*(3-r) +: 8] = b.frame_byte;
        else if (r == 12) tcp_doff = b.frame_byte[7:4];
        else if (r == 13) tcp_flags = b.frame_byte;
      end
      pos_cnt = p + 1;
    end
    if (!b.frame_end) return;
    done = 1'b1;
    if (link_on) begin
      l4 = ETH_HDR_BYTES + 4 * ip_ihl;
      s.dest_mac   = mac_dst;
      s.source_mac = mac_src;
      if (eth_type == ETHERTYPE_IPV4) begin
        s.source_ip         = ip_src;
        s.dest_ip           = ip_dst;
        s.frag_flag_bits    = ip_frag[14:13];
        s.frag_offset_bytes = {ip_frag[12:0], 3'b000};
        if (ip_proto == PROTO_TCP) begin
          s.layer_class   = LAYER_TCP;
          s.source_port   = l4_sport;
          s.dest_port     = l4_dport;
          s.tcp_flag_bits = tcp_flags;
          start           = l4 + 4 * tcp_doff;
        end else if (ip_proto == PROTO_UDP) begin
          s.layer_class = LAYER_UDP;
          s.source_port = l4_sport;
          s.dest_port   = l4_dport;
          start         = l4 + UDP_HDR_BYTES;
        end else begin
          s.layer_class = LAYER_IPV4;
          start         = l4;
        end
      end else begin
        s.layer_class = LAYER_ETH;
        start         = ETH_HDR_BYTES;
      end
      s.payload_start = start[7:0];
      s.payload_bytes = (pos_cnt > start) ? 16'(pos_cnt - start) : 16'd0;
    end
    // everything clears for the next frame
    pos_cnt   = 0;
    mac_dst   = '0;
    mac_src   = '0;
    eth_type  = '0;
    ip_ihl    = '0;
    ip_proto  = '0;
    ip_src    = '0;
    ip_dst    = '0;
    ip_frag   = '0;
    tcp_doff  = '0;
    l4_sport  = '0;
    l4_dport  = '0;
    tcp_flags = '0;
  endtask

  // summary of a short frame: everything past the mac addresses but the payload start is zero
  function automatic out_beat_t mk_sum(input layer_e c, input logic [47:0] dm,
                                       input logic [47:0] sm, input logic [7:0] st);
    out_beat_t s;
    s               = '0;
    s.layer_class   = c;
    s.dest_mac      = dm;
    s.source_mac    = sm;
    s.payload_start = st;
    return s;
  endfunction

  task automatic add_row(input logic link, input logic [7:0] byte_v, input logic last,
                         input logic typed, input out_beat_t want);
    dir_row_t row;
    row.link             = link;
    row.beat.frame_byte  = byte_v;
    row.beat.frame_end   = last;
    row.typed            = typed;
    row.want             = want;
    dir_tab = {dir_tab, row};
  endtask

  // offer one beat in bursts with random gaps; returns on the falling edge after the beat
  task automatic send_beat(input in_beat_t b, input logic typed, input out_beat_t want);
    bit        done;
    out_beat_t s;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_summary(b, done, s);
    if (done) pending_summaries = {pending_summaries, (typed ? want : s)};
    @(negedge clk_i);
  endtask

  // random frame: mostly well-formed tcp, udp and ipv4 headers, some cut short, some noise
  task automatic make_frame();
    int unsigned kind, ihl, doff, l4, hdr, n;
    logic [7:0]  k;
    kind = $urandom_range(0, 99);
    ihl  = 5;
    doff = 5;
    l4   = 34;
    frame_buf.delete();
    if (kind >= 90) begin
      n = $urandom_range(1, 70);
    end else if (kind >= 78) begin
      n = 14 + $urandom_range(0, 30);
    end else begin
      if ($urandom_range(0, 5) == 0) ihl = $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) doff = $urandom_range(0, 15);
      l4  = 14 + 4 * ihl;
      hdr = (kind < 30) ? ((doff < 5) ? 20 : 4 * doff) : ((kind < 55) ? 8 : 0);
      n   = ((l4 + hdr > 34) ? l4 + hdr : 34) + $urandom_range(0, 10);
    end
    repeat (n) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    if (kind < 78) begin
      if (kind < 30) begin
        k = frame_buf[l4 + 12];
        frame_buf[l4 + 12] = {doff[3:0], k[3:0]};
      end
      frame_buf[12] = ETHERTYPE_IPV4[15:8];
      frame_buf[13] = ETHERTYPE_IPV4[7:0];
      frame_buf[14] = {4'h4, ihl[3:0]};
      // largest fragment offset with both flag bits
      if ($urandom_range(0, 7) == 0) begin
        frame_buf[20] = 8'hff;
        frame_buf[21] = 8'hff;
      end
      if (kind < 30) frame_buf[23] = PROTO_TCP;
      else if (kind < 55) frame_buf[23] = PROTO_UDP;
    end
    // truncated frame
    if (kind < 90 && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, n);
      frame_buf = frame_buf[0:n-1];
    end
  endtask

  task automatic send_frame();
    in_beat_t b;
    for (int unsigned i = 0; i < frame_buf.size(); i++) begin
      b.frame_byte = frame_buf[i];
      b.frame_end  = (i == frame_buf.size() - 1);
      send_beat(b, 1'b0, '0);
    end
    rand_bytes += frame_buf.size();
  endtask

  // stop offering and wait until every owed summary has come out
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending_summaries.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_link(input logic v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    link_on = v;
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t %s: expected %0h, got %0h", $time, fname, want, got);
    end
  endtask

  // receiver: random stall patterns, plus a long hold-off on request
  initial begin
    stall_mode_e mode;
    int unsigned mode_left, hold_left;
    mode        = STALL_NONE;
    mode_left   = 0;
    hold_left   = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(4, 50);
        end
        mode_left--;
        case (mode)
          STALL_NONE: begin
            out_stall_i <= 1'b0;
          end
          STALL_RAND: begin
            out_stall_i <= ($urandom_range(0, 99) < 35);
          end
          default: begin
            out_stall_i <= ~out_stall_i;
          end
        endcase
      end
    end
  end

  // result beats against the oldest owed summary
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_summaries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t unexpected result beat %0h", $time, out_data_o);
      end else begin
        want = pending_summaries.pop_front();
        cmp_field("layer_class", want.layer_class, out_data_o.layer_class);
        cmp_field("dest_mac", want.dest_mac, out_data_o.dest_mac);
        cmp_field("source_mac", want.source_mac, out_data_o.source_mac);
        cmp_field("source_ip", want.source_ip, out_data_o.source_ip);
        cmp_field("dest_ip", want.dest_ip, out_data_o.dest_ip);
        cmp_field("source_port", want.source_port, out_data_o.source_port);
        cmp_field("dest_port", want.dest_port, out_data_o.dest_port);
        cmp_field("tcp_flag_bits", want.tcp_flag_bits, out_data_o.tcp_flag_bits);
        cmp_field("frag_flag_bits", want.frag_flag_bits, out_data_o.frag_flag_bits);
        cmp_field("frag_offset_bytes", want.frag_offset_bytes, out_data_o.frag_offset_bytes);
        cmp_field("payload_start", want.payload_start, out_data_o.payload_start);
        cmp_field("payload_bytes", want.payload_bytes, out_data_o.payload_bytes);
      end
    end
  end

  // watchdog: too long with no beat moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_beat_t b;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed frames, parsing on from reset
    // one-byte frames: only the top byte of the destination mac is known
    add_row(1'b1, 8'hff, 1'b1, 1'b1, mk_sum(LAYER_ETH, 48'hff00_0000_0000, '0, 8'd14));
    add_row(1'b1, 8'h00, 1'b1, 1'b1, mk_sum(LAYER_ETH, '0, '0, 8'd14));
    // parsing disabled: all fields zero
    add_row(1'b0, 8'ha5, 1'b1, 1'b1, mk_sum(LAYER_NONE, '0, '0, 8'd0));
    // frame cut right after the ipv4 ethertype: header length zero, protocol zero
    for (int unsigned i = 0; i < 14; i++) begin
      if (i < 6) add_row(1'b1, 8'hff, 1'b0, 1'b0, '0);
      else if (i < 12) add_row(1'b1, 8'h00, 1'b0, 1'b0, '0);
      else if (i == 12) add_row(1'b1, ETHERTYPE_IPV4[15:8], 1'b0, 1'b0, '0);
      else add_row(1'b1, ETHERTYPE_IPV4[7:0], 1'b1, 1'b1,
                   mk_sum(LAYER_IPV4, '1, '0, 8'd14));
    end
    gap_max = 3;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].link != link_on) begin
        drain_results();
        write_link(dir_tab[i].link);
      end
      send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
    end
    drain_results();

    // random frames with parsing on
    gap_max = 8;
    while (rand_bytes < 250) begin
      make_frame();
      send_frame();
    end

    // receiver holds off while one-byte frames keep coming, so the parser backs up
    drain_results();
    hold_req = 1'b1;
    gap_max  = 0;
    repeat (40) begin
      b.frame_byte = 8'($urandom_range(0, 255));
      b.frame_end  = 1'b1;
      send_beat(b, 1'b0, '0);
    end
    rand_bytes += 40;

    // sender pauses until everything is out, then parsing off
    drain_results();
    write_link(1'b0);
    gap_max = 8;
    while (rand_bytes < 340) begin
      make_frame();
      send_frame();
    end
    drain_results();
    write_link(1'b1);
    while (rand_bytes < 550) begin
      make_frame();
      send_frame();
    end
    drain_results();

    if (pending_summaries.size() != 0) mismatches += pending_summaries.size();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
